>>> rtl/bca_pkg.sv
// Package for the barometric compensation block.
// Holds the sequencer state type, command codes, register indexes and constants.
// No dependencies.
package bca_pkg;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_X1,
    ST_X2,
    ST_SQ,
    ST_B2SQ,
    ST_AC2,
    ST_AC3,
    ST_B1SQ,
    ST_B4,
    ST_B7,
    ST_P,
    ST_PSQ,
    ST_PC1,
    ST_PC2,
    ST_HGT,
    ST_SPD,
    ST_OUT
  } bca_state_t;

  localparam logic [1:0] ACT_SAMPLE  = 2'd0;
  localparam logic [1:0] ACT_CAPTURE = 2'd1;
  localparam logic [1:0] ACT_CLEAR   = 2'd2;

  localparam logic [2:0] REG_CAL_A  = 3'd0;
  localparam logic [2:0] REG_CAL_B  = 3'd1;
  localparam logic [2:0] REG_CAL_C  = 3'd2;
  localparam logic [2:0] REG_CAL_MD = 3'd3;
  localparam logic [2:0] REG_OSS    = 3'd4;
  localparam logic [2:0] REG_RATE   = 3'd5;

  localparam logic signed [63:0] T_OFFSET   = 64'sd4000;
  localparam logic [15:0]        B7_SCALE   = 16'd50000;
  localparam logic signed [63:0] B7_LIMIT   = 64'sh0000_0000_8000_0000;
  localparam logic signed [63:0] PC_SQ      = 64'sd3038;
  localparam logic signed [63:0] PC_LIN     = -64'sd7357;
  localparam logic signed [63:0] PC_OFS     = 64'sd3791;
  // Reciprocal of 57 scaled by 2^30, exact for dividends below 2^24.
  localparam logic signed [63:0] HGT_RECIP  = 64'sd18837576;

endpackage

>>> rtl/bca_ifs.sv
// Valid/ready channel interfaces for the input and result words.
// Depends on nothing.
interface bca_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [15:0] raw_temp;
  logic [23:0] raw_pressure_word;
  modport source (output valid, action, raw_temp, raw_pressure_word, input ready);
  modport sink (input valid, action, raw_temp, raw_pressure_word, output ready);
endinterface

interface bca_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] temperature;
  logic [16:0]        pressure_pa;
  logic [16:0]        reference_pa;
  logic signed [18:0] height;
  logic signed [23:0] vertical_speed;
  modport source (output valid, temperature, pressure_pa, reference_pa, height,
                  vertical_speed, input ready);
  modport sink (input valid, temperature, pressure_pa, reference_pa, height,
                vertical_speed, output ready);
endinterface

>>> rtl/barometric_compensation_altitude.sv
// Barometric compensation, reference pressure and relative height/speed.
// Depends on bca_pkg and the channel interfaces in bca_ifs.sv.
//
// Channel   Dir  Handshake            Contents
// in_ch     in   valid/ready          action, raw_temp, raw_pressure_word
// out_ch    out  valid/ready          temperature, pressure, reference, height, speed
// APB       in   psel/penable/pwrite  calibration words, oversampling, update rate
//
// A sample's result word is computed with two 64-step divisions on the shared divider
// (skipped when the divisor is zero) and thirteen four-phase products on the shared
// 32x32 multiplier. A capture, clear or undefined command goes straight to the result.
// Reset is synchronous and active low and clears the sequencer, unit control and
// output registers, and sets the configuration registers to their defaults.
// The input is not ready again until the result word has been taken.
module barometric_compensation_altitude
  import bca_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  bca_in_if.sink      in_ch,
  bca_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic [47:0] cal_a_r, cal_b_r, cal_c_r;
  logic [15:0] md_r;
  logic [1:0]  oss_r;
  logic [9:0]  rate_r;

  bca_state_t state_r, state_nxt;
  logic       pend_r;

  logic [15:0] ut_r;
  logic [23:0] rawp_r;

  logic signed [63:0] x1_r, x3_r, b5_r, sq_r, b3_r, b4_r, b7_r, p_r;
  logic signed [18:0] hgt_r;
  logic signed [15:0] lt_r;
  logic [16:0]        lp_r, ref_r;
  logic signed [18:0] lh_r;
  logic signed [23:0] speed_r;

  logic               eng_busy_r, eng_div_r, done_r;
  logic signed [63:0] res_r;
  logic [63:0]        ma_r, mb_r, prod_r, acc_r;
  logic [1:0]         mph_r;
  logic [63:0]        dq_r, rem_r, dv_r;
  logic               neg_r;
  logic [5:0]         cnt_r;

  logic               start, sdiv, skip, comp, fin;
  logic signed [63:0] opa, opb, cap;

  function automatic logic signed [63:0] sx16(input logic [15:0] v);
    sx16 = {{48{v[15]}}, v};
  endfunction

  function automatic logic signed [63:0] zx16(input logic [15:0] v);
    zx16 = {48'd0, v};
  endfunction

  logic signed [63:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = sx16(cal_a_r[47:32]);
  assign ac2 = sx16(cal_a_r[31:16]);
  assign ac3 = sx16(cal_a_r[15:0]);
  assign ac4 = zx16(cal_b_r[47:32]);
  assign ac5 = zx16(cal_b_r[31:16]);
  assign ac6 = zx16(cal_b_r[15:0]);
  assign b1  = sx16(cal_c_r[47:32]);
  assign b2  = sx16(cal_c_r[31:16]);
  assign mc  = sx16(cal_c_r[15:0]);
  assign md  = sx16(md_r);

  logic [23:0]        up_w;
  logic [15:0]        b7s_w;
  logic signed [63:0] b6_w, t_w, x3a_w, v_w, b3_w, x3b_w, pc_w, p2_w, ph_w, pd_w;
  logic signed [63:0] dif_w, dabs_w, hq_w, hs_w;
  logic               dbl_w;
  logic [16:0]        lp_w;

  assign up_w  = rawp_r >> (4'd8 - {2'b00, oss_r});
  assign b7s_w = B7_SCALE >> oss_r;
  assign b6_w  = b5_r - T_OFFSET;
  assign t_w   = (b5_r + 64'sd8) >>> 4;
  assign x3a_w = x1_r + (res_r >>> 11);
  assign v_w   = (((ac1 <<< 2) + x3a_w) <<< oss_r) + 64'sd2;
  assign b3_w  = (v_w + (v_w[63] ? 64'sd3 : 64'sd0)) >>> 2;
  assign x3b_w = (x1_r + (res_r >>> 16) + 64'sd2) >>> 2;
  assign dbl_w = !(b7_r >= 64'sd0 && b7_r < B7_LIMIT);
  assign pd_w  = dbl_w ? (cap <<< 1) : cap;
  assign ph_w  = p_r >>> 8;
  assign pc_w  = (x1_r + (res_r >>> 16) + PC_OFS) >>> 4;
  assign p2_w  = p_r + pc_w;
  assign lp_w  = (p2_w < 64'sd0) ? 17'd0 : ((p2_w > 64'sd131071) ? 17'h1ffff : p2_w[16:0]);
  assign dif_w = 64'(signed'({1'b0, ref_r})) - 64'(signed'({1'b0, lp_r}));
  assign dabs_w = dif_w[63] ? -dif_w : dif_w;
  assign hq_w  = res_r >>> 30;
  assign hs_w  = dif_w[63] ? -hq_w : hq_w;
  assign cap   = skip ? 64'sd0 : res_r;

  // Sequencer: next state and operand selection for the shared unit.
  always_comb begin
    state_nxt    = state_r;
    sdiv         = 1'b0;
    skip         = 1'b0;
    comp         = 1'b1;
    opa          = 64'sd0;
    opb          = 64'sd0;
    in_ch.ready  = 1'b0;
    out_ch.valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        comp = 1'b0;
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          state_nxt = (in_ch.action == ACT_SAMPLE) ? ST_X1 : ST_OUT;
        end
      end
      ST_X1: begin
        opa = zx16(ut_r) - ac6;
        opb = ac5;
      end
      ST_X2: begin
        sdiv = 1'b1;
        opa = mc <<< 11;
        opb = x1_r + md;
        skip = (opb == 64'sd0);
      end
      ST_SQ: begin
        opa = b6_w;
        opb = b6_w;
      end
      ST_B2SQ: begin
        opa = b2;
        opb = sq_r;
      end
      ST_AC2: begin
        opa = ac2;
        opb = b6_w;
      end
      ST_AC3: begin
        opa = ac3;
        opb = b6_w;
      end
      ST_B1SQ: begin
        opa = b1;
        opb = sq_r;
      end
      ST_B4: begin
        opa = ac4;
        opb = x3_r + 64'sd32768;
      end
      ST_B7: begin
        opa = {40'd0, up_w} - b3_r;
        opb = zx16(b7s_w);
      end
      ST_P: begin
        sdiv = 1'b1;
        opa = dbl_w ? b7_r : (b7_r <<< 1);
        opb = b4_r;
        skip = (b4_r == 64'sd0);
      end
      ST_PSQ: begin
        opa = ph_w;
        opb = ph_w;
      end
      ST_PC1: begin
        opa = x1_r;
        opb = PC_SQ;
      end
      ST_PC2: begin
        opa = PC_LIN;
        opb = p_r;
      end
      ST_HGT: begin
        opa = (dabs_w <<< 6) + (dabs_w <<< 4);
        opb = HGT_RECIP;
      end
      ST_SPD: begin
        opa = 64'(hgt_r) - 64'(lh_r);
        opb = {54'd0, rate_r};
      end
      ST_OUT: begin
        comp = 1'b0;
        out_ch.valid = 1'b1;
        if (out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        comp = 1'b0;
        state_nxt = ST_IDLE;
      end
    endcase
    start = comp && !pend_r && !skip;
    fin   = comp && (skip || done_r);
    if (fin) begin
      state_nxt = bca_state_t'(state_r + 5'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (start) begin
        pend_r <= 1'b1;
      end else if (done_r) begin
        pend_r <= 1'b0;
      end
    end
  end

  // Shared unit: 64-bit wrapping multiply from three 32x32 products, or a
  // signed truncating divide one quotient bit per cycle.
  logic [31:0] mul_x, mul_y;
  logic [63:0] trial;
  logic        ge;
  logic [63:0] qnext;
  assign mul_x = (mph_r == 2'd1) ? ma_r[63:32] : ma_r[31:0];
  assign mul_y = (mph_r == 2'd2) ? mb_r[63:32] : mb_r[31:0];
  assign trial = {rem_r[62:0], dq_r[63]};
  assign ge    = (trial >= dv_r);
  assign qnext = {dq_r[62:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eng_busy_r <= 1'b0;
      eng_div_r  <= 1'b0;
      done_r     <= 1'b0;
      mph_r      <= 2'd0;
      cnt_r      <= 6'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        eng_busy_r <= 1'b1;
        eng_div_r  <= sdiv;
        mph_r      <= 2'd0;
        cnt_r      <= 6'd0;
        ma_r       <= opa;
        mb_r       <= opb;
        dq_r       <= opa[63] ? 64'(-opa) : opa;
        dv_r       <= opb[63] ? 64'(-opb) : opb;
        neg_r      <= opa[63] ^ opb[63];
        rem_r      <= 64'd0;
      end else if (eng_busy_r && eng_div_r) begin
        rem_r <= ge ? (trial - dv_r) : trial;
        dq_r  <= qnext;
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          res_r      <= neg_r ? signed'(64'(-qnext)) : signed'(qnext);
          eng_busy_r <= 1'b0;
          done_r     <= 1'b1;
        end
      end else if (eng_busy_r) begin
        prod_r <= mul_x * mul_y;
        mph_r  <= mph_r + 2'd1;
        case (mph_r)
          2'd1: acc_r <= prod_r;
          2'd2: acc_r <= acc_r + {prod_r[31:0], 32'd0};
          2'd3: begin
            res_r      <= signed'(acc_r + {prod_r[31:0], 32'd0});
            eng_busy_r <= 1'b0;
            done_r     <= 1'b1;
          end
          default: acc_r <= acc_r;
        endcase
      end
    end
  end

  // Datapath captures and block state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lt_r    <= 16'sd0;
      lp_r    <= 17'd0;
      ref_r   <= 17'd0;
      lh_r    <= 19'sd0;
      speed_r <= 24'sd0;
    end else begin
      if (state_r == ST_IDLE && in_ch.valid) begin
        ut_r    <= in_ch.raw_temp;
        rawp_r  <= in_ch.raw_pressure_word;
        speed_r <= 24'sd0;
        if (in_ch.action == ACT_CAPTURE) begin
          ref_r <= lp_r;
        end else if (in_ch.action == ACT_CLEAR) begin
          ref_r <= 17'd0;
        end
      end
      if (fin) begin
        case (state_r)
          ST_X1:   x1_r <= res_r >>> 15;
          ST_X2:   b5_r <= x1_r + cap;
          ST_SQ:   sq_r <= res_r >>> 12;
          ST_B2SQ: x1_r <= res_r >>> 11;
          ST_AC2:  b3_r <= b3_w;
          ST_AC3:  x1_r <= res_r >>> 13;
          ST_B1SQ: x3_r <= x3b_w;
          ST_B4:   b4_r <= res_r >>> 15;
          ST_B7:   b7_r <= res_r;
          ST_P: begin
            if (pd_w > 64'sd2147483647) begin
              p_r <= 64'sd2147483647;
            end else if (pd_w < -64'sd2147483648) begin
              p_r <= -64'sd2147483648;
            end else begin
              p_r <= pd_w;
            end
          end
          ST_PSQ:  x1_r <= res_r;
          ST_PC1:  x1_r <= res_r >>> 16;
          ST_PC2: begin
            lp_r <= lp_w;
            if (t_w > 64'sd32767) begin
              lt_r <= 16'sh7fff;
            end else if (t_w < -64'sd32768) begin
              lt_r <= -16'sh8000;
            end else begin
              lt_r <= t_w[15:0];
            end
            if (ref_r == 17'd0) begin
              ref_r <= lp_w;
            end
          end
          ST_HGT: begin
            if (hs_w > 64'sd262143) begin
              hgt_r <= 19'sd262143;
            end else if (hs_w < -64'sd262144) begin
              hgt_r <= -19'sd262144;
            end else begin
              hgt_r <= hs_w[18:0];
            end
          end
          ST_SPD: begin
            lh_r <= hgt_r;
            if (res_r > 64'sd8388607) begin
              speed_r <= 24'sd8388607;
            end else if (res_r < -64'sd8388608) begin
              speed_r <= -24'sd8388608;
            end else begin
              speed_r <= res_r[23:0];
            end
          end
          default: x1_r <= x1_r;
        endcase
      end
    end
  end

  assign out_ch.temperature    = lt_r;
  assign out_ch.pressure_pa    = lp_r;
  assign out_ch.reference_pa   = ref_r;
  assign out_ch.height         = lh_r;
  assign out_ch.vertical_speed = speed_r;

  // Configuration registers.
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_a_r <= 48'd0;
      cal_b_r <= 48'd0;
      cal_c_r <= 48'd0;
      md_r    <= 16'd0;
      oss_r   <= 2'd3;
      rate_r  <= 10'd10;
    end else if (cfg_wr) begin
      case (paddr[5:3])
        REG_CAL_A:  cal_a_r <= pwdata[47:0];
        REG_CAL_B:  cal_b_r <= pwdata[47:0];
        REG_CAL_C:  cal_c_r <= pwdata[47:0];
        REG_CAL_MD: md_r    <= pwdata[15:0];
        REG_OSS:    oss_r   <= pwdata[1:0];
        REG_RATE:   rate_r  <= pwdata[9:0];
        default:    md_r    <= md_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[5:3])
      REG_CAL_A:  prdata = {16'd0, cal_a_r};
      REG_CAL_B:  prdata = {16'd0, cal_b_r};
      REG_CAL_C:  prdata = {16'd0, cal_c_r};
      REG_CAL_MD: prdata = {48'd0, md_r};
      REG_OSS:    prdata = {62'd0, oss_r};
      REG_RATE:   prdata = {54'd0, rate_r};
      default:    prdata = 64'd0;
    endcase
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid)) else $error("input ready while a result waits");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !eng_busy_r) else $error("shared unit started while busy");
  a_done_pend: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> pend_r) else $error("unit finished with no request pending");
  a_back_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready) |=> in_ch.ready) else $error("no return to idle");

endmodule
